// ===== rtl/inr_pkg.sv =====
// Shared types and constants for the integer n-th root block.
// Holds the item structs, the sequencer state enum and derived widths.
// No dependencies.
package inr_pkg;

    localparam int RADICAND_BITS = 31;
    localparam int EXP_BITS      = 6;
    // Bounds need one extra bit: the low bound can step to radicand + 1.
    localparam int BOUND_BITS    = RADICAND_BITS + 1;
    localparam int PROD_BITS     = 2 * RADICAND_BITS;

    typedef struct packed {
        logic [EXP_BITS-1:0]      exponent;
        logic [RADICAND_BITS-1:0] radicand;
    } in_item_t;

    typedef struct packed {
        logic [RADICAND_BITS-1:0] root;
        logic                     found;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_CHK,
        ST_EVAL
    } state_t;

endpackage

// ===== rtl/integer_nth_root.sv =====
// Exact integer n-th root by bisection over 1..radicand.
// Uses inr_pkg for item structs, state enum and widths.
//
// Usage: present an item on request and raise start; it is taken at a rising
// edge where start is high and busy is low. busy stays high while the item is
// worked on. The result appears on result for exactly one cycle with done high;
// the receiver cannot stall it, so it must take it in that cycle.
// found=1 gives the exact root; otherwise root is 0 (a zero radicand never
// finds a root; exponent 0 finds root 1 only for radicand 1).
// Sequencing: one shared 31x31 multiplier, registered, then a compare against the
// radicand, so each multiply step passes through ST_MUL and then ST_CHK. A probe
// computes the midpoint (ST_SETUP), runs k <= n multiplies (stopped early on
// overshoot), then a last step check and a final compare (ST_EVAL). Up to 31
// probes. Any midpoint above 1 overshoots within 31 multiplies; the probe at
// midpoint 1 never overshoots and runs all n multiplies. Probes typically end
// well short of that because powers overshoot early. One item at a time.
// busy drops in the cycle done is high, so a new item may be started then.
// Reset: rst_n asynchronous, active low; returns to idle with no result pending.
module integer_nth_root (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  inr_pkg::in_item_t  request,
    output logic              done,
    output inr_pkg::out_item_t result
);
    import inr_pkg::*;

    state_t                    state_reg, state_next;
    logic [EXP_BITS-1:0]       n_reg, n_next;
    logic [RADICAND_BITS-1:0]  m_reg, m_next;
    logic [BOUND_BITS-1:0]     lo_reg, lo_next;
    logic [BOUND_BITS-1:0]     hi_reg, hi_next;
    logic [RADICAND_BITS-1:0]  mid_reg, mid_next;
    logic [RADICAND_BITS-1:0]  prod_reg, prod_next;
    logic [EXP_BITS-1:0]       cnt_reg, cnt_next;
    logic [PROD_BITS-1:0]      full_reg, full_next;
    out_item_t                 result_reg, result_next;
    logic                      done_reg, done_next;

    logic                      accept;
    logic                      range_ok;
    logic                      steps_done;
    logic                      over;
    logic [BOUND_BITS-1:0]     mid_calc;

    assign accept     = start && (state_reg == ST_IDLE);
    assign range_ok   = (lo_reg <= hi_reg);
    assign steps_done = (cnt_reg == n_reg);
    assign over       = (full_reg > {{(PROD_BITS-RADICAND_BITS){1'b0}}, m_reg});
    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >> 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = range_ok ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                state_next = steps_done ? ST_EVAL : ST_CHK;
            end
            ST_CHK:
            begin
                state_next = over ? ST_SETUP : ST_MUL;
            end
            ST_EVAL:
            begin
                state_next = (prod_reg == m_reg) ? ST_IDLE : ST_SETUP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        n_next      = n_reg;
        m_next      = m_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        prod_next   = prod_reg;
        cnt_next    = cnt_reg;
        full_next   = full_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next  = request.exponent;
                    m_next  = request.radicand;
                    lo_next = BOUND_BITS'(1);
                    hi_next = {1'b0, request.radicand};
                end
            end
            ST_SETUP:
            begin
                mid_next  = mid_calc[RADICAND_BITS-1:0];
                prod_next = RADICAND_BITS'(1);
                cnt_next  = '0;
                if (!range_ok)
                begin
                    result_next.root  = '0;
                    result_next.found = 1'b0;
                    done_next         = 1'b1;
                end
            end
            ST_MUL:
            begin
                full_next = PROD_BITS'(prod_reg) * PROD_BITS'(mid_reg);
            end
            ST_CHK:
            begin
                if (over)
                    hi_next = {1'b0, mid_reg} - BOUND_BITS'(1);
                else
                begin
                    prod_next = full_reg[RADICAND_BITS-1:0];
                    cnt_next  = cnt_reg + EXP_BITS'(1);
                end
            end
            ST_EVAL:
            begin
                if (prod_reg == m_reg)
                begin
                    result_next.root  = mid_reg;
                    result_next.found = 1'b1;
                    done_next         = 1'b1;
                end
                else if (prod_reg < m_reg)
                    lo_next = {1'b0, mid_reg} + BOUND_BITS'(1);
                else
                    hi_next = {1'b0, mid_reg} - BOUND_BITS'(1);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        m_reg      <= m_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        prod_reg   <= prod_next;
        cnt_reg    <= cnt_next;
        full_reg   <= full_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/inr_checker.sv =====
// Port-level checker for integer_nth_root, bound into integer_nth_root.
// Uses inr_pkg for the item structs.
// Watches the start/busy/done sequencing and result consistency.
module inr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input inr_pkg::out_item_t result
);
    import inr_pkg::*;

    // an accepted item keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only ends a busy stretch
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without preceding work");

    // not found always reports a zero root
    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.root == '0))
        else $error("root nonzero without found");

    // a found root is never zero
    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> (result.root != '0))
        else $error("found with zero root");

endmodule

bind integer_nth_root inr_checker u_inr_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
